// ===== rtl/core/etok_pkg.sv =====
package etok_pkg;

    // lexer mode
    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_NUMBER = 2'd1,
        MODE_MATRIX = 2'd2,
        MODE_IDENT  = 2'd3
    } t_lex_mode;

    // state carried from one character to the next
    typedef struct packed {
        t_lex_mode mode;
        logic      unary_allowed;
        logic      minus_held;
    } t_lex_state;

    // one result item
    typedef struct packed {
        logic [7:0] out_char;
        logic       token_start;
        logic       end_marker;
        logic       function_error;
        logic       last_of_run;
    } t_result;

    // everything one character produces
    typedef struct packed {
        t_result    res0;
        t_result    res1;
        logic [1:0] count;
        t_lex_state next;
    } t_lex_out;

    localparam t_lex_state LEX_RESET = '{mode: MODE_IDLE, unary_allowed: 1'b1,
                                         minus_held: 1'b0};

    // characters with a special role in the lexer
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = PTR_W + 1;

endpackage

// ===== rtl/core/etok_lexer.sv =====
module etok_lexer (
    input  etok_pkg::t_lex_state i_state,
    input  logic [7:0]           i_char,
    input  logic                 i_eot,
    output etok_pkg::t_lex_out   o_lex
);
    import etok_pkg::*;

    typedef struct packed {
        logic       valid;
        t_result    res;
        t_lex_state st;
    } t_char_step;

    function automatic logic is_digit(logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic t_result mk(logic [7:0] c, logic start);
        t_result r;
        r.out_char       = c;
        r.token_start    = start;
        r.end_marker     = 1'b0;
        r.function_error = 1'b0;
        r.last_of_run    = 1'b0;
        return r;
    endfunction

    // lex one character with no minus pending
    function automatic t_char_step lex_char(t_lex_state s, logic [7:0] c);
        t_char_step r;
        r.valid = 1'b1;
        r.res   = mk(c, 1'b0);
        r.st    = s;
        unique case (s.mode)
            MODE_IDENT: begin
                if (c == CH_LPAREN) begin
                    r.res.token_start  = 1'b1;
                    r.st.mode          = MODE_IDLE;
                    r.st.unary_allowed = 1'b1;
                end
            end
            MODE_MATRIX: begin
                if (c == CH_RBRACK) r.st.mode = MODE_IDLE;
            end
            MODE_IDLE, MODE_NUMBER: begin
                if (!(s.mode == MODE_NUMBER && (is_digit(c) || c == CH_POINT))) begin
                    r.st.mode = MODE_IDLE;
                    if (c == CH_MINUS && s.unary_allowed) begin
                        r.st.minus_held = 1'b1;
                        r.valid         = 1'b0;
                    end else begin
                        r.res.token_start = 1'b1;
                        if (is_digit(c) || c == CH_POINT) begin
                            r.st.mode          = MODE_NUMBER;
                            r.st.unary_allowed = 1'b0;
                        end else if (c == CH_LBRACK) begin
                            r.st.mode = MODE_MATRIX;
                        end else if (is_letter(c)) begin
                            r.st.mode = MODE_IDENT;
                        end else if (c == CH_LPAREN) begin
                            r.st.unary_allowed = 1'b1;
                        end else begin
                            r.st.unary_allowed = (c != CH_RPAREN);
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    t_char_step lc_plain;
    t_char_step lc_after;
    t_lex_state st_after;
    t_result    marker;

    // held minus is released before the new character is lexed
    always_comb begin
        st_after               = i_state;
        st_after.minus_held    = 1'b0;
        st_after.unary_allowed = 1'b1;
        lc_plain               = lex_char(i_state, i_char);
        lc_after               = lex_char(st_after, i_char);
    end

    always_comb begin
        marker                = mk(8'h00, 1'b0);
        marker.end_marker     = 1'b1;
        marker.function_error = (i_state.mode == MODE_IDENT);
        o_lex.res0  = mk(i_char, 1'b0);
        o_lex.res1  = mk(i_char, 1'b0);
        o_lex.count = 2'd0;
        o_lex.next  = i_state;
        if (i_eot) begin
            // flush minus, then end marker
            o_lex.next = LEX_RESET;
            if (i_state.minus_held) begin
                o_lex.res0  = mk(CH_MINUS, 1'b1);
                o_lex.res1  = marker;
                o_lex.count = 2'd2;
            end else begin
                o_lex.res0  = marker;
                o_lex.count = 2'd1;
            end
        end else if (i_state.minus_held) begin
            o_lex.res0 = mk(CH_MINUS, 1'b1);
            if (is_digit(i_char)) begin
                // minus opens a signed number
                o_lex.res1  = mk(i_char, 1'b0);
                o_lex.count = 2'd2;
                o_lex.next  = '{mode: MODE_NUMBER, unary_allowed: 1'b0,
                                minus_held: 1'b0};
            end else begin
                o_lex.res1  = lc_after.res;
                o_lex.count = lc_after.valid ? 2'd2 : 2'd1;
                o_lex.next  = lc_after.st;
            end
        end else begin
            o_lex.res0  = lc_plain.res;
            o_lex.count = lc_plain.valid ? 2'd1 : 2'd0;
            o_lex.next  = lc_plain.st;
        end
        // mark final result of this transaction
        if (o_lex.count == 2'd2) o_lex.res1.last_of_run = 1'b1;
        else if (o_lex.count == 2'd1) o_lex.res0.last_of_run = 1'b1;
    end

endmodule

// ===== rtl/core/etok_out_fifo.sv =====
module etok_out_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [1:0]                    i_push_count,
    input  etok_pkg::t_result             i_data0,
    input  etok_pkg::t_result             i_data1,
    input  logic                          i_pop,
    output logic [etok_pkg::CNT_W-1:0]    o_count,
    output etok_pkg::t_result             o_head
);
    import etok_pkg::*;

    t_result            r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [PTR_W-1:0]   wr_ptr1;

    // advance pointers and occupancy
    always_comb begin
        wr_ptr1  = r_wr_ptr + PTR_W'(1);
        n_wr_ptr = r_wr_ptr + PTR_W'(i_push_count);
        n_rd_ptr = r_rd_ptr + PTR_W'(i_pop);
        n_count  = r_count + CNT_W'(i_push_count) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // store up to two results per transaction
    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) r_mem[r_wr_ptr] <= i_data0;
        if (i_push_count == 2'd2) r_mem[wr_ptr1]  <= i_data1;
    end

    assign o_count = r_count;
    assign o_head  = r_mem[r_rd_ptr];

endmodule

// ===== rtl/core/expression_tokenizer.sv =====
// Channel  Dir  tdata              tuser                                  tlast
// s_axis   in   [7:0] char_code    -                                      end_of_text
// m_axis   out  [7:0] out_char     [0] token_start [1] end_marker         last_of_run
//                                  [2] function_error
//
// One input character is taken per cycle while s_axis_tready is high; each produces zero,
// one or two results, so sustained input rate is bounded by the output beats drained.
// Results go through a four-entry queue; input stalls when fewer than two
// entries are free. Results are registered in the queue before they are offered.
// Synchronous active-low reset empties the queue and returns the lexer to idle.
module expression_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_char
    output logic [2:0]  m_axis_tuser,   // [0] token_start, [1] end_marker, [2] function_error
    output logic        m_axis_tlast
);
    import etok_pkg::*;

    t_lex_state         r_state;
    t_lex_out           lex;
    logic               in_accept;
    logic               out_pop;
    logic [CNT_W-1:0]   fifo_count;
    t_result            head;
    logic [1:0]         push_count;

    etok_lexer u_lexer (
        .i_state (r_state),
        .i_char  (s_axis_tdata),
        .i_eot   (s_axis_tlast),
        .o_lex   (lex)
    );

    // accept while two queue entries are free
    assign s_axis_tready = (fifo_count <= CNT_W'(FIFO_DEPTH - 2));
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_pop       = m_axis_tvalid && m_axis_tready;
    assign push_count    = in_accept ? lex.count : 2'd0;

    // hold lexer state between characters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LEX_RESET;
        end else if (in_accept) begin
            r_state <= lex.next;
        end
    end

    etok_out_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (push_count),
        .i_data0      (lex.res0),
        .i_data1      (lex.res1),
        .i_pop        (out_pop),
        .o_count      (fifo_count),
        .o_head       (head)
    );

    assign m_axis_tvalid = (fifo_count != '0);
    assign m_axis_tdata  = head.out_char;
    assign m_axis_tuser  = {head.function_error, head.end_marker, head.token_start};
    assign m_axis_tlast  = head.last_of_run;

endmodule

// ===== rtl/core/etok_checker.sv =====
module etok_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    input  logic [2:0]  m_axis_tuser,
    input  logic        m_axis_tlast
);
    import etok_pkg::*;

    // stalled output transaction stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

    // end marker carries no character and closes the run
    a_marker_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            m_axis_tdata == 8'h00 && !m_axis_tuser[0] && m_axis_tlast)
        else $error("malformed end marker");

    // function error only flagged on the end marker
    a_ferr_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1])
        else $error("function error outside end marker");

    // any input transaction other than a minus produces a result
    a_in_produces: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tlast || s_axis_tdata != CH_MINUS)
            |=> m_axis_tvalid)
        else $error("no result after input transaction");

    // reset empties the result queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind expression_tokenizer etok_checker u_etok_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== sim/expression_tokenizer_tb.sv =====
`timescale 1ns / 100ps

module expression_tokenizer_tb;
    import etok_pkg::*;

    localparam int RAND_ITEMS  = 400;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_PRINTS  = 50;

    // one row of the directed stimulus; typed rows carry their own expected result
    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
        logic       typed;
        t_result    res;
    } t_dir_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;     // [7:0] char_code
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;             // [7:0] out_char
    logic [2:0] m_axis_tuser;             // [0] token_start, [1] end_marker, [2] function_error
    logic       m_axis_tlast;

    // typed expectation travels with the character it belongs to
    logic       row_typed = 1'b0;
    t_result    row_res = '0;

    t_dir_row   dir_rows[$];
    logic [8:0] stim_plan[$];             // [8] end_of_text, [7:0] char_code
    t_result    pending_tokens[$];
    logic       gap_free = 1'b0;
    int         err_count = 0;
    int         cyc_count = 0;

    // lexer state of the predictor
    t_lex_mode  pm_mode;
    logic       pm_unary;
    logic       pm_minus;
    t_result    tok_res[2];
    int         tok_cnt;

    expression_tokenizer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // abort a hung run
    always @(posedge i_clk) begin
        cyc_count <= cyc_count + 1;
        if (cyc_count > CYCLE_LIMIT) begin
            $display("[expression_tokenizer] ERROR");
            $finish;
        end
    end

    function automatic t_result mk(input logic [7:0] c, input logic st, input logic em,
                                   input logic fe, input logic last);
        t_result r;
        r.out_char       = c;
        r.token_start    = st;
        r.end_marker     = em;
        r.function_error = fe;
        r.last_of_run    = last;
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < MAX_PRINTS)
            $display("mismatch at cycle %0d: %s got %0h want %0h", cyc_count, what, got, want);
        err_count++;
    endtask

    task automatic restart_expression();
        pm_mode  = LEX_RESET.mode;
        pm_unary = LEX_RESET.unary_allowed;
        pm_minus = LEX_RESET.minus_held;
    endtask

    task automatic emit(input t_result r);
        tok_res[tok_cnt] = r;
        tok_cnt++;
    endtask

    // lex one character with no minus pending
    task automatic lex_plain(input logic [7:0] c);
        logic numc;
        numc = is_digit(c) || c == CH_POINT;
        if (pm_mode == MODE_IDENT) begin
            emit(mk(c, c == CH_LPAREN, 1'b0, 1'b0, 1'b0));
            if (c == CH_LPAREN) begin
                pm_mode  = MODE_IDLE;
                pm_unary = 1'b1;
            end
        end else if (pm_mode == MODE_MATRIX) begin
            emit(mk(c, 1'b0, 1'b0, 1'b0, 1'b0));
            if (c == CH_RBRACK)
                pm_mode = MODE_IDLE;
        end else if (pm_mode == MODE_NUMBER && numc) begin
            emit(mk(c, 1'b0, 1'b0, 1'b0, 1'b0));
        end else begin
            // any open number closes here; lex from idle
            pm_mode = MODE_IDLE;
            if (c == CH_MINUS && pm_unary) begin
                pm_minus = 1'b1;
            end else begin
                emit(mk(c, 1'b1, 1'b0, 1'b0, 1'b0));
                if (numc) begin
                    pm_mode  = MODE_NUMBER;
                    pm_unary = 1'b0;
                end else if (c == CH_LBRACK) begin
                    pm_mode = MODE_MATRIX;
                end else if (is_letter(c)) begin
                    pm_mode = MODE_IDENT;
                end else begin
                    pm_unary = (c != CH_RPAREN);
                end
            end
        end
    endtask

    // expected results of one accepted character
    task automatic tokenize_step(input logic [7:0] c, input logic eot);
        tok_cnt = 0;
        if (eot) begin
            if (pm_minus)
                emit(mk(CH_MINUS, 1'b1, 1'b0, 1'b0, 1'b0));
            emit(mk(8'h00, 1'b0, 1'b1, pm_mode == MODE_IDENT, 1'b0));
            restart_expression();
        end else if (pm_minus) begin
            // release the held minus; a digit makes it a sign
            pm_minus = 1'b0;
            emit(mk(CH_MINUS, 1'b1, 1'b0, 1'b0, 1'b0));
            if (is_digit(c)) begin
                emit(mk(c, 1'b0, 1'b0, 1'b0, 1'b0));
                pm_mode  = MODE_NUMBER;
                pm_unary = 1'b0;
            end else begin
                pm_unary = 1'b1;
                lex_plain(c);
            end
        end else begin
            lex_plain(c);
        end
        if (tok_cnt > 0)
            tok_res[tok_cnt-1].last_of_run = 1'b1;
    endtask

    // predict on input transactions, check output transactions
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                tokenize_step(s_axis_tdata, s_axis_tlast);
                if (row_typed)
                    pending_tokens = {pending_tokens, row_res};
                else
                    for (int i = 0; i < tok_cnt; i++)
                        pending_tokens = {pending_tokens, tok_res[i]};
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.out_char       = m_axis_tdata;
                got.token_start    = m_axis_tuser[0];
                got.end_marker     = m_axis_tuser[1];
                got.function_error = m_axis_tuser[2];
                got.last_of_run    = m_axis_tlast;
                if (pending_tokens.size() == 0) begin
                    report_mismatch("unexpected result", int'(got), 0);
                end else begin
                    want = pending_tokens.pop_front();
                    if (got.out_char !== want.out_char)
                        report_mismatch("out_char", int'(got.out_char),
                                        int'(want.out_char));
                    if (got.token_start !== want.token_start)
                        report_mismatch("token_start", int'(got.token_start),
                                        int'(want.token_start));
                    if (got.end_marker !== want.end_marker)
                        report_mismatch("end_marker", int'(got.end_marker),
                                        int'(want.end_marker));
                    if (got.function_error !== want.function_error)
                        report_mismatch("function_error", int'(got.function_error),
                                        int'(want.function_error));
                    if (got.last_of_run !== want.last_of_run)
                        report_mismatch("last_of_run", int'(got.last_of_run),
                                        int'(want.last_of_run));
                end
            end
        end
    end

    // output backpressure: random, one long hold-off, one stretch always ready
    initial begin
        int rx_cyc;
        rx_cyc = 0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            rx_cyc++;
            if (rx_cyc >= 150 && rx_cyc < 270)
                m_axis_tready <= 1'b0;
            else if (rx_cyc >= 500 && rx_cyc < 800)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 99) >= 27);
        end
    end

    task automatic add_row(input logic [7:0] c, input logic eot, input logic typed,
                           input t_result res);
        t_dir_row r;
        r.ch    = c;
        r.eot   = eot;
        r.typed = typed;
        r.res   = res;
        dir_rows = {dir_rows, r};
    endtask

    // offer one character and hold it until the transaction completes
    task automatic offer(input logic [7:0] c, input logic eot, input logic typed,
                         input t_result res);
        while (!gap_free && $urandom_range(0, 99) < 27) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= eot;
        row_typed     <= typed;
        row_res       <= res;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // stop offering until every expected result has come back
    task automatic drain_wait();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_tokens.size() != 0);
    endtask

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1))
            return 8'($urandom_range(65, 90));
        return 8'($urandom_range(97, 122));
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'($urandom_range(48, 57));
    endfunction

    // append one character to the stimulus plan
    task automatic plan_char(input logic eot, input logic [7:0] c);
        stim_plan = {stim_plan, {eot, c}};
    endtask

    // queue up one random expression fragment
    task automatic plan_fragment();
        string ops;
        string cells;
        int    n;
        ops   = "+-*/^,";
        cells = "0123456789,; -.";
        case ($urandom_range(0, 11))
            0, 1: begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    plan_char(1'b0, ($urandom_range(0, 4) == 0) ? CH_POINT : rand_digit());
            end
            2: begin
                plan_char(1'b0, CH_MINUS);
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    plan_char(1'b0, rand_digit());
            end
            3, 4: plan_char(1'b0, 8'(ops[$urandom_range(0, 5)]));
            5:    plan_char(1'b0, CH_LPAREN);
            6:    plan_char(1'b0, CH_RPAREN);
            7: begin
                plan_char(1'b0, CH_LBRACK);
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    plan_char(1'b0, 8'(cells[$urandom_range(0, 14)]));
                plan_char(1'b0, CH_RBRACK);
            end
            8: begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    plan_char(1'b0, rand_letter());
                plan_char(1'b0, CH_LPAREN);
            end
            9:  plan_char(1'b0, 8'($urandom_range(0, 255)));
            10: plan_char(1'b1, 8'($urandom_range(0, 255)));
            default: begin
                // identifier left open at end of text
                plan_char(1'b0, rand_letter());
                plan_char(1'b1, 8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    // main stimulus
    initial begin
        logic [8:0] nxt;
        restart_expression();

        // number, signs, identifier, matrix, end of text and the extremes
        add_row("5", 1'b0, 1'b1, mk("5", 1'b1, 1'b0, 1'b0, 1'b1));
        add_row(".", 1'b0, 1'b0, '0);
        add_row("+", 1'b0, 1'b0, '0);
        add_row("-", 1'b0, 1'b0, '0);
        add_row("7", 1'b0, 1'b0, '0);
        add_row("-", 1'b0, 1'b0, '0);
        add_row("-", 1'b0, 1'b0, '0);
        add_row(".", 1'b0, 1'b0, '0);
        add_row("(", 1'b0, 1'b0, '0);
        add_row("-", 1'b0, 1'b0, '0);
        add_row("x", 1'b0, 1'b0, '0);
        add_row(" ", 1'b0, 1'b0, '0);
        add_row("(", 1'b0, 1'b0, '0);
        add_row("[", 1'b0, 1'b0, '0);
        add_row("1", 1'b0, 1'b0, '0);
        add_row("]", 1'b0, 1'b0, '0);
        add_row(")", 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b1, 1'b1, mk(8'h00, 1'b0, 1'b1, 1'b0, 1'b1));
        add_row("a", 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b1, 1'b1, mk(8'h00, 1'b0, 1'b1, 1'b1, 1'b1));
        add_row("-", 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b1, 1'b0, '0);
        add_row("[", 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b1, 1'b1, mk(8'h00, 1'b0, 1'b1, 1'b0, 1'b1));
        add_row(8'hFF, 1'b0, 1'b1, mk(8'hFF, 1'b1, 1'b0, 1'b0, 1'b1));
        add_row(8'h00, 1'b0, 1'b1, mk(8'h00, 1'b1, 1'b0, 1'b0, 1'b1));
        add_row(8'hA5, 1'b1, 1'b1, mk(8'h00, 1'b0, 1'b1, 1'b0, 1'b1));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            offer(dir_rows[i].ch, dir_rows[i].eot, dir_rows[i].typed, dir_rows[i].res);
        drain_wait();

        // random expressions with some noise
        for (int k = 0; k < RAND_ITEMS; k++) begin
            if (k == RAND_ITEMS / 2)
                drain_wait();
            gap_free = (k >= 100 && k < 180);
            if (stim_plan.size() == 0)
                plan_fragment();
            nxt = stim_plan.pop_front();
            offer(nxt[7:0], nxt[8], 1'b0, '0);
        end
        drain_wait();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (pending_tokens.size() != 0)
            report_mismatch("results missing", 0, pending_tokens.size());
        if (err_count == 0)
            $display("[expression_tokenizer] OK");
        else
            $display("[expression_tokenizer] ERROR");
        $finish;
    end

endmodule
